// File: sv/psgeg_pkg.sv
// Package for the envelope generator: widths, shape bit positions, request codes,
// the shared item/result structs and the one-step envelope update function.
// No dependencies.
package psgeg_pkg;

	localparam int PERIOD_BITS = 24;
	localparam int LEVEL_BITS  = 4;
	localparam int SHAPE_BITS  = 4;

	localparam logic [LEVEL_BITS-1:0] LEVEL_TOP    = 4'd15;
	localparam logic [LEVEL_BITS-1:0] LEVEL_BOTTOM = 4'd0;

	// bit positions inside the shape register
	localparam int SHAPE_CONT = 3;
	localparam int SHAPE_ATT  = 2;
	localparam int SHAPE_ALT  = 1;
	localparam int SHAPE_HOLD = 0;

	typedef enum logic {
		REQ_TICK  = 1'b0,
		REQ_SHAPE = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic                  req_type;
		logic                  tick_cycles;
		logic [SHAPE_BITS-1:0] shape_value;
	} item_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] env_level;
		logic                  is_holding;
	} result_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] level;
		logic                  up;
		logic                  hold;
	} env_state_t;

	// One level step, including the end-of-ramp behavior.
	function automatic env_state_t env_step(input env_state_t cur,
			input logic [SHAPE_BITS-1:0] shape);
		env_state_t nxt;
		nxt = cur;
		priority if (!cur.up && cur.level != LEVEL_BOTTOM) begin
			nxt.level = cur.level - 4'd1;
		end else if (cur.up && cur.level != LEVEL_TOP) begin
			nxt.level = cur.level + 4'd1;
		end else if (!shape[SHAPE_CONT]) begin
			nxt.level = LEVEL_BOTTOM;
			nxt.hold  = 1'b1;
		end else if (shape[SHAPE_HOLD]) begin
			if (shape[SHAPE_ALT]) begin
				nxt.level = cur.up ? LEVEL_BOTTOM : LEVEL_TOP;
			end
			nxt.hold = 1'b1;
		end else if (shape[SHAPE_ALT]) begin
			nxt.up = !cur.up;
		end else begin
			nxt.level = shape[SHAPE_ATT] ? LEVEL_BOTTOM : LEVEL_TOP;
		end
		return nxt;
	endfunction

endpackage

// File: sv/psgeg_intf.sv
// Valid/ready channel interfaces for the envelope generator request and result beats.
// Depends on psgeg_pkg for field widths.
interface psgeg_req_if;
	logic                            valid;
	logic                            ready;
	logic                            req_type;
	logic                            tick_cycles;
	logic [psgeg_pkg::SHAPE_BITS-1:0] shape_value;

	modport source (output valid, req_type, tick_cycles, shape_value, input ready);
	modport sink   (input valid, req_type, tick_cycles, shape_value, output ready);
endinterface

interface psgeg_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [psgeg_pkg::LEVEL_BITS-1:0] env_level;
	logic                            is_holding;

	modport source (output valid, env_level, is_holding, input ready);
	modport sink   (input valid, env_level, is_holding, output ready);
endinterface

// File: sv/psgeg_core.sv
// Envelope state (level, direction, hold, step counter, shape, period) and its update.
// Depends on psgeg_pkg.
module psgeg_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  psgeg_pkg::item_t                  item,
	input  logic                              cfg_we,
	input  logic [psgeg_pkg::PERIOD_BITS-1:0] cfg_wdata,
	output psgeg_pkg::result_t                result
);
	import psgeg_pkg::*;

	env_state_t             env_q, env_d;
	logic [SHAPE_BITS-1:0]  shape_q, shape_d;
	logic [PERIOD_BITS-1:0] period_q, period_d;
	logic [PERIOD_BITS-1:0] count_q, count_d;
	logic [PERIOD_BITS:0]   count_inc;
	logic                   step_due;

	// the count stays below the period, so count+1 reaching it is the only step case
	assign count_inc = {1'b0, count_q} + {{PERIOD_BITS{1'b0}}, 1'b1};
	assign step_due  = (count_inc == {1'b0, period_q});

	always_comb begin
		env_d    = env_q;
		shape_d  = shape_q;
		period_d = period_q;
		count_d  = count_q;
		if (fire) begin
			if (item.req_type == REQ_SHAPE) begin
				shape_d     = item.shape_value;
				env_d.up    = item.shape_value[SHAPE_ATT];
				env_d.level = item.shape_value[SHAPE_ATT] ? LEVEL_BOTTOM : LEVEL_TOP;
				env_d.hold  = 1'b0;
				count_d     = '0;
			end else if (item.tick_cycles && !env_q.hold && period_q != '0) begin
				if (step_due) begin
					count_d = '0;
					env_d   = env_step(env_q, shape_q);
				end else begin
					count_d = count_inc[PERIOD_BITS-1:0];
				end
			end
		end
		if (cfg_we) begin
			period_d = cfg_wdata;
			if (cfg_wdata == '0 || count_q >= cfg_wdata) begin
				count_d = '0;
			end
		end
	end

	assign result.env_level  = env_d.level;
	assign result.is_holding = env_d.hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q    <= '{level: LEVEL_TOP, up: 1'b0, hold: 1'b0};
			shape_q  <= '0;
			period_q <= '0;
			count_q  <= '0;
		end else begin
			env_q    <= env_d;
			shape_q  <= shape_d;
			period_q <= period_d;
			count_q  <= count_d;
		end
	end

	a_count_below_period: assert property (@(posedge clk) disable iff (!arst_n)
		period_q != '0 |-> count_q < period_q)
		else $error("step counter reached the period");

	a_shape_clears_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.req_type == REQ_SHAPE |=> !env_q.hold && count_q == '0)
		else $error("shape write did not restart the envelope");

	a_hold_freezes_level: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.req_type == REQ_TICK && env_q.hold |=> $stable(env_q))
		else $error("envelope moved while holding");

endmodule

// File: sv/psgeg_stage.sv
// Input register stage: captures a request beat and releases it to the envelope update.
// Depends on psgeg_pkg and psgeg_intf.
module psgeg_stage (
	input  logic              clk,
	input  logic              arst_n,
	psgeg_req_if.sink         req,
	input  logic              advance,
	output logic              valid_s1,
	output psgeg_pkg::item_t  item_s1
);
	import psgeg_pkg::*;

	// take a new beat whenever the held one leaves or there is none
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= '{req_type: req.req_type, tick_cycles: req.tick_cycles,
				shape_value: req.shape_value};
		end
	end

endmodule

// File: sv/psg_envelope_generator_top.sv
// Top level of the envelope generator: input stage, envelope state update, result register.
// Depends on psgeg_pkg, psgeg_intf, psgeg_stage and psgeg_core.
//
// Envelope generator of a three-voice sound chip. Each request beat is either a clock
// tick (req_type 0, tick_cycles 0 or 1) or a write of the 4-bit shape register
// (req_type 1: continue, attack, alternate, hold). Every request beat yields exactly one
// result beat with the level after that request and the holding flag. The step period
// is written through cfg_we/cfg_wdata in ticks per level step, zero stops stepping;
// write it only while no request is in flight. The block takes one request per cycle
// while the result side does not stall: a request is held in the input register, its
// envelope update is a single 24-bit increment-and-compare plus a 4-bit level step,
// and the result is registered in the result register, which offers the result beat
// until it is taken. Back pressure on the result side stalls the input register and,
// through it, req.ready.
module psg_envelope_generator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	psgeg_req_if.sink                         req,
	psgeg_rsp_if.source                       rsp,
	input  logic                              cfg_we,
	input  logic [psgeg_pkg::PERIOD_BITS-1:0] cfg_wdata
);
	import psgeg_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	logic    fire;
	result_t result;
	logic    rsp_valid_q;
	result_t rsp_data_q;

	// advance the held request whenever the result register is free or being drained
	assign advance = !rsp_valid_q || rsp.ready;
	assign fire    = valid_s1 && advance;

	psgeg_stage u_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// envelope level, direction, hold and shape update only on the cycle a request leaves the input register
	psgeg_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

	// result register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_data_q <= result;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.env_level  = rsp_data_q.env_level;
	assign rsp.is_holding = rsp_data_q.is_holding;

	a_fire_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q)
		else $error("processed request produced no result beat");

	a_stall_holds_request: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stalled request lost");

	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !valid_s1 |=> !rsp_valid_q)
		else $error("result beat without a request");

endmodule
